>>> hdl/dirp_pkg.sv
package dirp_pkg;

   // width of the sector size register and default position counter width
   localparam int SECTOR_SIZE_W       = 16;
   localparam int SECTOR_POS_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF     = 4;

   localparam logic [SECTOR_SIZE_W-1:0] SECTOR_SIZE_RESET = 16'd2048;

   // record layout
   localparam logic [7:0] MIN_REC_LEN   = 8'd34;
   localparam logic [7:0] NAME_OFS      = 8'd33;
   localparam logic [7:0] NAME_LEN_POS  = 8'd32;
   localparam logic [7:0] FLAGS_POS     = 8'd25;
   localparam logic [7:0] DIR_FLAG_MASK = 8'h02;
   localparam logic [7:0] NAME_CUT_CHAR = 8'h3B;

   // result kinds
   typedef enum logic [1:0] {
      KIND_NAME    = 2'd0,
      KIND_SUMMARY = 2'd1,
      KIND_ERROR   = 2'd2,
      KIND_END     = 2'd3
   } dirp_kind_type;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_SHORT    = 3'd1;
   localparam logic [2:0] ERR_OVERRUN  = 3'd2;
   localparam logic [2:0] ERR_ENDIAN   = 3'd3;
   localparam logic [2:0] ERR_NAME_LEN = 3'd4;

   // all results caused by one input beat: up to two name bytes, then one tail result
   typedef struct packed {
      logic          last;
      logic          c0_valid;
      logic [7:0]    c0_char;
      logic          c1_valid;
      logic [7:0]    c1_char;
      logic          tail_valid;
      dirp_kind_type tail_kind;
      logic [31:0]   tail_lba;
      logic [31:0]   tail_length;
      logic          tail_dir;
      logic [2:0]    tail_error;
   } dirp_bundle_type;

   localparam int BUNDLE_W = $bits(dirp_bundle_type);

endpackage

>>> hdl/dirp_fifo.sv
module dirp_fifo import dirp_pkg::*; #(
   parameter int WIDTH = BUNDLE_W,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count lost a push");

endmodule

>>> hdl/dirp_front.sv
module dirp_front import dirp_pkg::*; #(
   parameter int SECTOR_POS_BITS = SECTOR_POS_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_extent,
   input  logic                     csr_wr_en,
   input  logic [SECTOR_SIZE_W-1:0] csr_wr_data,
   output logic                     push,
   output dirp_bundle_type          bundle
);

   localparam int CNT_W = SECTOR_SIZE_W + 1;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_RECORD = 4'b0010,
      MODE_SKIP   = 4'b0100,
      MODE_HALT   = 4'b1000
   } mode_type;

   logic [SECTOR_SIZE_W-1:0]   sector_size_ff;
   logic [SECTOR_POS_BITS-1:0] sector_pos_ff, sector_pos_in;
   logic [7:0]                 rec_pos_ff, rec_pos_in;
   logic [7:0]                 rec_len_ff, rec_len_in;
   logic [7:0]                 name_len_ff, name_len_in;
   logic [31:0]                lba_lo_ff, lba_lo_in;
   logic [31:0]                lba_hi_ff, lba_hi_in;
   logic [31:0]                size_lo_ff, size_lo_in;
   logic [31:0]                size_hi_ff, size_hi_in;
   logic                       dir_ff, dir_in;
   logic [7:0]                 held_char_ff, held_char_in;
   logic                       held_valid_ff, held_valid_in;
   logic                       name_cut_ff, name_cut_in;
   logic                       drop_ff, drop_in;
   mode_type                   mode_ff, mode_in;

   logic [CNT_W-1:0] pos_next;
   logic             wrap;
   logic [7:0]       name_idx;
   logic [7:0]       up_char;
   logic             stop;

   // sector boundary tracking
   assign pos_next = CNT_W'(sector_pos_ff) + CNT_W'(1);
   assign wrap     = (pos_next >= {1'b0, sector_size_ff}) || pos_next[SECTOR_POS_BITS];
   assign name_idx = rec_pos_ff - NAME_OFS;
   assign up_char  = (data_byte >= 8'h61 && data_byte <= 8'h7A) ? data_byte - 8'h20 : data_byte;

   // per-beat parse step
   always_comb begin
      sector_pos_in = wrap ? '0 : pos_next[SECTOR_POS_BITS-1:0];
      rec_pos_in    = rec_pos_ff;
      rec_len_in    = rec_len_ff;
      name_len_in   = name_len_ff;
      lba_lo_in     = lba_lo_ff;
      lba_hi_in     = lba_hi_ff;
      size_lo_in    = size_lo_ff;
      size_hi_in    = size_hi_ff;
      dir_in        = dir_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      name_cut_in   = name_cut_ff;
      drop_in       = drop_ff;
      mode_in       = mode_ff;
      stop          = 1'b0;
      bundle        = '0;
      bundle.tail_kind = KIND_NAME;

      case (mode_ff)
         MODE_IDLE: begin
            if (data_byte == 8'd0) begin
               mode_in = wrap ? MODE_IDLE : MODE_SKIP;
            end else begin
               // record start
               rec_pos_in    = 8'd1;
               rec_len_in    = data_byte;
               name_len_in   = '0;
               lba_lo_in     = '0;
               lba_hi_in     = '0;
               size_lo_in    = '0;
               size_hi_in    = '0;
               dir_in        = 1'b0;
               held_char_in  = '0;
               held_valid_in = 1'b0;
               name_cut_in   = 1'b0;
               drop_in       = 1'b0;
               if (data_byte < MIN_REC_LEN) begin
                  bundle.tail_valid = 1'b1;
                  bundle.tail_kind  = KIND_ERROR;
                  bundle.tail_error = ERR_SHORT;
                  mode_in           = MODE_HALT;
               end else if (end_of_extent) begin
                  bundle.tail_valid = 1'b1;
                  bundle.tail_kind  = KIND_ERROR;
                  bundle.tail_error = ERR_OVERRUN;
                  mode_in           = MODE_HALT;
               end else begin
                  mode_in = MODE_RECORD;
               end
            end
         end
         MODE_RECORD: begin
            if (end_of_extent && ({1'b0, rec_pos_ff} + 9'd1 < {1'b0, rec_len_ff})) begin
               bundle.tail_valid = 1'b1;
               bundle.tail_kind  = KIND_ERROR;
               bundle.tail_error = ERR_OVERRUN;
               mode_in           = MODE_HALT;
            end else begin
               // field capture by position
               case (rec_pos_ff)
                  8'd2:  lba_lo_in[7:0]    = data_byte;
                  8'd3:  lba_lo_in[15:8]   = data_byte;
                  8'd4:  lba_lo_in[23:16]  = data_byte;
                  8'd5:  lba_lo_in[31:24]  = data_byte;
                  8'd6, 8'd7, 8'd8, 8'd9: lba_hi_in = {lba_hi_ff[23:0], data_byte};
                  8'd10: size_lo_in[7:0]   = data_byte;
                  8'd11: size_lo_in[15:8]  = data_byte;
                  8'd12: size_lo_in[23:16] = data_byte;
                  8'd13: size_lo_in[31:24] = data_byte;
                  8'd14, 8'd15, 8'd16: size_hi_in = {size_hi_ff[23:0], data_byte};
                  8'd17: begin
                     size_hi_in = {size_hi_ff[23:0], data_byte};
                     if (lba_lo_ff != lba_hi_ff || size_lo_ff != {size_hi_ff[23:0], data_byte})
                     begin
                        bundle.tail_valid = 1'b1;
                        bundle.tail_kind  = KIND_ERROR;
                        bundle.tail_error = ERR_ENDIAN;
                        mode_in           = MODE_HALT;
                        stop              = 1'b1;
                     end
                  end
                  FLAGS_POS: dir_in = (data_byte & DIR_FLAG_MASK) != 8'd0;
                  NAME_LEN_POS: begin
                     name_len_in = data_byte;
                     if ({1'b0, NAME_OFS} + {1'b0, data_byte} > {1'b0, rec_len_ff}) begin
                        bundle.tail_valid = 1'b1;
                        bundle.tail_kind  = KIND_ERROR;
                        bundle.tail_error = ERR_NAME_LEN;
                        mode_in           = MODE_HALT;
                        stop              = 1'b1;
                     end
                  end
                  default: begin
                     // name bytes, first one held back
                     if (rec_pos_ff >= NAME_OFS && name_idx < name_len_ff) begin
                        if (!name_cut_ff) begin
                           if (data_byte == NAME_CUT_CHAR) begin
                              name_cut_in = 1'b1;
                           end else if (name_idx == 8'd0) begin
                              held_char_in  = up_char;
                              held_valid_in = 1'b1;
                           end else begin
                              if (held_valid_ff) begin
                                 bundle.c0_valid = 1'b1;
                                 bundle.c0_char  = held_char_ff;
                                 held_valid_in   = 1'b0;
                              end
                              bundle.c1_valid = 1'b1;
                              bundle.c1_char  = up_char;
                           end
                        end
                        if ({1'b0, name_idx} + 9'd1 == {1'b0, name_len_ff} && held_valid_in)
                        begin
                           if (held_char_in <= 8'd1) begin
                              drop_in = 1'b1;
                           end else begin
                              bundle.c0_valid = 1'b1;
                              bundle.c0_char  = held_char_in;
                           end
                           held_valid_in = 1'b0;
                        end
                     end
                  end
               endcase

               // advance and close the record
               if (!stop) begin
                  rec_pos_in = rec_pos_ff + 8'd1;
                  if ({1'b0, rec_pos_ff} + 9'd1 >= {1'b0, rec_len_ff}) begin
                     if (!drop_in) begin
                        bundle.tail_valid  = 1'b1;
                        bundle.tail_kind   = KIND_SUMMARY;
                        bundle.tail_lba    = lba_lo_ff;
                        bundle.tail_length = size_lo_ff;
                        bundle.tail_dir    = dir_ff;
                     end
                     rec_pos_in    = '0;
                     rec_len_in    = '0;
                     name_len_in   = '0;
                     lba_lo_in     = '0;
                     lba_hi_in     = '0;
                     size_lo_in    = '0;
                     size_hi_in    = '0;
                     dir_in        = 1'b0;
                     held_char_in  = '0;
                     held_valid_in = 1'b0;
                     name_cut_in   = 1'b0;
                     drop_in       = 1'b0;
                     mode_in       = MODE_IDLE;
                  end
               end
            end
         end
         MODE_SKIP: begin
            if (wrap) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // extent end closes everything
      if (end_of_extent) begin
         if (!bundle.c0_valid && !bundle.c1_valid && !bundle.tail_valid) begin
            bundle.tail_valid = 1'b1;
            bundle.tail_kind  = KIND_END;
         end
         bundle.last   = 1'b1;
         sector_pos_in = '0;
         rec_pos_in    = '0;
         rec_len_in    = '0;
         name_len_in   = '0;
         lba_lo_in     = '0;
         lba_hi_in     = '0;
         size_lo_in    = '0;
         size_hi_in    = '0;
         dir_in        = 1'b0;
         held_char_in  = '0;
         held_valid_in = 1'b0;
         name_cut_in   = 1'b0;
         drop_in       = 1'b0;
         mode_in       = MODE_IDLE;
      end
   end

   assign push = accept && (bundle.c0_valid || bundle.c1_valid || bundle.tail_valid);

   // sector size register
   always_ff @(posedge clock) begin
      if (reset) begin
         sector_size_ff <= SECTOR_SIZE_RESET;
      end else if (csr_wr_en) begin
         sector_size_ff <= csr_wr_data;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         sector_pos_ff <= '0;
         rec_pos_ff    <= '0;
         rec_len_ff    <= '0;
         name_len_ff   <= '0;
         lba_lo_ff     <= '0;
         lba_hi_ff     <= '0;
         size_lo_ff    <= '0;
         size_hi_ff    <= '0;
         dir_ff        <= 1'b0;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         name_cut_ff   <= 1'b0;
         drop_ff       <= 1'b0;
         mode_ff       <= MODE_IDLE;
      end else if (accept) begin
         sector_pos_ff <= sector_pos_in;
         rec_pos_ff    <= rec_pos_in;
         rec_len_ff    <= rec_len_in;
         name_len_ff   <= name_len_in;
         lba_lo_ff     <= lba_lo_in;
         lba_hi_ff     <= lba_hi_in;
         size_lo_ff    <= size_lo_in;
         size_hi_ff    <= size_hi_in;
         dir_ff        <= dir_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         name_cut_ff   <= name_cut_in;
         drop_ff       <= drop_in;
         mode_ff       <= mode_in;
      end
   end

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_extent) |=> (mode_ff == MODE_IDLE && sector_pos_ff == '0))
      else $error("extent end did not return to idle");
   a_end_pushes_last: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_extent) |-> (push && bundle.last))
      else $error("extent end produced no final result");
   a_held_in_record: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (mode_ff == MODE_RECORD || mode_ff == MODE_HALT))
      else $error("held name byte outside a record");

endmodule

>>> hdl/dirp_back.sv
module dirp_back import dirp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  dirp_bundle_type head,
   input  logic            empty,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_name_char,
   output logic [31:0]     rsp_extent_lba,
   output logic [31:0]     rsp_data_length,
   output logic            rsp_is_directory,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last
);

   logic [2:0]  done_ff, done_in;
   logic [2:0]  avail;
   logic [2:0]  sel;
   logic [2:0]  remain;
   logic        load;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  char_ff, char_in;
   logic [31:0] lba_ff, lba_in;
   logic [31:0] len_ff, len_in;
   logic        dir_ff, dir_in;
   logic [2:0]  err_ff, err_in;
   logic        last_ff, last_in;

   // slots of the head beat still to send
   assign avail  = {head.tail_valid, head.c1_valid, head.c0_valid} & ~done_ff & {3{!empty}};
   assign sel    = avail & (~avail + 3'd1);
   assign remain = avail & ~sel;
   assign load   = !valid_ff || !rsp_stall;
   assign pop    = load && (avail != 3'd0) && (remain == 3'd0);

   // output register load
   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      char_in  = char_ff;
      lba_in   = lba_ff;
      len_in   = len_ff;
      dir_in   = dir_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = (avail != 3'd0);
         kind_in  = KIND_NAME;
         char_in  = '0;
         lba_in   = '0;
         len_in   = '0;
         dir_in   = 1'b0;
         err_in   = ERR_NONE;
         last_in  = head.last && (remain == 3'd0);
         case (sel)
            3'b001: char_in = head.c0_char;
            3'b010: char_in = head.c1_char;
            3'b100: begin
               kind_in = head.tail_kind;
               lba_in  = head.tail_lba;
               len_in  = head.tail_length;
               dir_in  = head.tail_dir;
               err_in  = head.tail_error;
            end
            default: last_in = 1'b0;
         endcase
         if (avail != 3'd0) begin
            done_in = (remain == 3'd0) ? 3'd0 : (done_ff | sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      lba_ff  <= lba_in;
      len_ff  <= len_in;
      dir_ff  <= dir_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_name_char    = char_ff;
   assign rsp_extent_lba   = lba_ff;
   assign rsp_data_length  = len_ff;
   assign rsp_is_directory = dir_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_last         = last_ff;

   a_done_clears_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (done_ff == 3'd0))
      else $error("slot mask not cleared after pop");
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(sel))
      else $error("more than one slot selected");
   a_pop_only_loaded: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff)
      else $error("beat popped without a result shown");

endmodule

>>> hdl/iso9660_dir_record_parser.sv
// channel   dir  handshake          payload
// req_      in   req_valid/stall    data_byte, end_of_extent
// rsp_      out  rsp_valid/stall    kind, name_char, extent_lba, data_length,
//                                   is_directory, error_code, last
// csr_      in   csr_wr_en          wr_data: sector_size
//
// one input beat per cycle unless stalled; its results (zero to three) leave one per cycle
// while rsp_stall is low, each through the parse step, the queue and the output reg
// the byte rate is set by the output port: beats with two or three results fill the queue
// req_stall rises only when the result queue is full
// reset is synchronous; sector size returns to 2048 and the parser waits for a record start
module iso9660_dir_record_parser import dirp_pkg::*; #(
   parameter int SECTOR_POS_BITS = SECTOR_POS_BITS_DEF,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_end_of_extent,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_name_char,
   output logic [31:0]              rsp_extent_lba,
   output logic [31:0]              rsp_data_length,
   output logic                     rsp_is_directory,
   output logic [2:0]               rsp_error_code,
   output logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [SECTOR_SIZE_W-1:0] csr_wr_data
);

   logic                accept;
   logic                push;
   logic                pop;
   logic                full;
   logic                empty;
   dirp_bundle_type     push_bundle;
   dirp_bundle_type     head_bundle;
   logic [BUNDLE_W-1:0] push_bits;
   logic [BUNDLE_W-1:0] head_bits;

   assign req_stall   = full;
   assign accept      = req_valid && !req_stall;
   assign push_bits   = push_bundle;
   assign head_bundle = dirp_bundle_type'(head_bits);

   // parse front
   dirp_front #(
      .SECTOR_POS_BITS(SECTOR_POS_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .end_of_extent (req_end_of_extent),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .push          (push),
      .bundle        (push_bundle)
   );

   // result queue
   dirp_fifo #(
      .WIDTH(BUNDLE_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (push_bits),
      .pop     (pop),
      .rd_data (head_bits),
      .full    (full),
      .empty   (empty)
   );

   // result serializer
   dirp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head_bundle),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_name_char    (rsp_name_char),
      .rsp_extent_lba   (rsp_extent_lba),
      .rsp_data_length  (rsp_data_length),
      .rsp_is_directory (rsp_is_directory),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last)
   );

endmodule

>>> sim/iso9660_dir_record_parser_tb.sv
`timescale 1ns / 1ps

module iso9660_dir_record_parser_tb;
   import dirp_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 10;
   localparam int IDLE_PCT       = 35;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int POS_MASK       = (1 << SECTOR_POS_BITS_DEF) - 1;

   // record layout offsets
   localparam int LBA_LE_AT   = 2;
   localparam int LBA_BE_AT   = 6;
   localparam int SIZE_LE_AT  = 10;
   localparam int SIZE_BE_AT  = 14;
   localparam int FLAGS_AT    = FLAGS_POS;
   localparam int NAME_LEN_AT = NAME_LEN_POS;
   localparam int NAME_AT     = NAME_OFS;
   localparam int MIN_LEN     = MIN_REC_LEN;
   localparam int MAX_LEN     = 255;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_RECORD,
      SCAN_PADDING,
      SCAN_HALTED
   } scan_mode_t;

   typedef struct packed {
      dirp_kind_type kind;
      logic [7:0]    name_char;
      logic [31:0]   extent_lba;
      logic [31:0]   data_length;
      logic          is_directory;
      logic [2:0]    error_code;
      logic          last;
   } dir_result_t;

   // dut ports driven here, all known from time zero
   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_data_byte     = 8'h00;
   logic                     req_end_of_extent = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall         = 1'b0;
   logic [1:0]               rsp_kind;
   logic [7:0]               rsp_name_char;
   logic [31:0]              rsp_extent_lba;
   logic [31:0]              rsp_data_length;
   logic                     rsp_is_directory;
   logic [2:0]               rsp_error_code;
   logic                     rsp_last;
   logic                     csr_wr_en         = 1'b0;
   logic [SECTOR_SIZE_W-1:0] csr_wr_data       = '0;

   // parser mirror state
   int          sector_bytes;
   int          sec_pos;
   int          rec_pos;
   int          rec_len;
   int          nm_len;
   logic [31:0] lba_le;
   logic [31:0] lba_be;
   logic [31:0] sz_le;
   logic [31:0] sz_be;
   logic        dir_bit;
   logic [7:0]  held_ch;
   bit          held_v;
   bit          nm_cut;
   bit          rec_drop;
   scan_mode_t  scan_mode;

   dir_result_t beat_results[$];
   dir_result_t results_due[$];
   int          results_parsed = 0;
   int          fail_count     = 0;

   // extent under construction
   logic [7:0] extent_q[$];
   logic [7:0] name_q[$];

   // traffic shaping
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   int holds_asked   = 0;
   int holds_granted = 0;
   int hold_left     = 0;
   int stuck_cycles  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   iso9660_dir_record_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_extent(req_end_of_extent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_name_char    (rsp_name_char),
      .rsp_extent_lba   (rsp_extent_lba),
      .rsp_data_length  (rsp_data_length),
      .rsp_is_directory (rsp_is_directory),
      .rsp_error_code   (rsp_error_code),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // ---------------- parser mirror ----------------

   function automatic void clear_record_state();
      rec_pos  = 0;
      rec_len  = 0;
      nm_len   = 0;
      lba_le   = '0;
      lba_be   = '0;
      sz_le    = '0;
      sz_be    = '0;
      dir_bit  = 1'b0;
      held_ch  = '0;
      held_v   = 1'b0;
      nm_cut   = 1'b0;
      rec_drop = 1'b0;
   endfunction

   function automatic void reset_parser_mirror();
      sector_bytes = SECTOR_SIZE_RESET;
      clear_record_state();
      sec_pos   = 0;
      scan_mode = SCAN_IDLE;
   endfunction

   function automatic void push_result(input dirp_kind_type k, input logic [7:0] ch,
                                       input logic [31:0] lba, input logic [31:0] len,
                                       input logic dir, input logic [2:0] err);
      dir_result_t r;
      r.kind         = k;
      r.name_char    = ch;
      r.extent_lba   = lba;
      r.data_length  = len;
      r.is_directory = dir;
      r.error_code   = err;
      r.last         = 1'b0;
      beat_results.push_back(r);
   endfunction

   function automatic void raise_error(input logic [2:0] code);
      push_result(KIND_ERROR, 8'h00, '0, '0, 1'b0, code);
      scan_mode = SCAN_HALTED;
   endfunction

   // one byte inside a record past its length byte
   function automatic void take_record_byte(input logic [7:0] b);
      int         p;
      int         idx;
      logic [7:0] ch;
      p = rec_pos;
      if (p >= LBA_LE_AT && p < LBA_LE_AT + 4) begin
         lba_le |= 32'(b) << (8 * (p - LBA_LE_AT));
      end else if (p >= LBA_BE_AT && p < LBA_BE_AT + 4) begin
         lba_be = {lba_be[23:0], b};
      end else if (p >= SIZE_LE_AT && p < SIZE_LE_AT + 4) begin
         sz_le |= 32'(b) << (8 * (p - SIZE_LE_AT));
      end else if (p >= SIZE_BE_AT && p < SIZE_BE_AT + 4) begin
         sz_be = {sz_be[23:0], b};
         if (p == SIZE_BE_AT + 3 && (lba_le != lba_be || sz_le != sz_be)) begin
            raise_error(ERR_ENDIAN);
            return;
         end
      end else if (p == FLAGS_AT) begin
         dir_bit = (b & DIR_FLAG_MASK) != 8'h00;
      end else if (p == NAME_LEN_AT) begin
         nm_len = b;
         if (NAME_AT + nm_len > rec_len) begin
            raise_error(ERR_NAME_LEN);
            return;
         end
      end else if (p >= NAME_AT && p - NAME_AT < nm_len) begin
         idx = p - NAME_AT;
         if (!nm_cut) begin
            if (b == NAME_CUT_CHAR) begin
               nm_cut = 1'b1;
            end else begin
               // lower case letters to upper case
               ch = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
               if (idx == 0) begin
                  held_ch = ch;
                  held_v  = 1'b1;
               end else begin
                  if (held_v) begin
                     push_result(KIND_NAME, held_ch, '0, '0, 1'b0, ERR_NONE);
                     held_v = 1'b0;
                  end
                  push_result(KIND_NAME, ch, '0, '0, 1'b0, ERR_NONE);
               end
            end
         end
         // a lone 0x00 or 0x01 name is a dot entry and vanishes
         if (idx + 1 == nm_len && held_v) begin
            if (held_ch <= 8'h01) rec_drop = 1'b1;
            else push_result(KIND_NAME, held_ch, '0, '0, 1'b0, ERR_NONE);
            held_v = 1'b0;
         end
      end
      rec_pos = (p + 1) & 8'hFF;
      if (p + 1 >= rec_len) begin
         if (!rec_drop) push_result(KIND_SUMMARY, 8'h00, lba_le, sz_le, dir_bit, ERR_NONE);
         clear_record_state();
         scan_mode = SCAN_IDLE;
      end
   endfunction

   function automatic void parse_dir_byte(input logic [7:0] b, input logic eoe);
      int          next_pos;
      bit          wrap;
      dir_result_t r;
      next_pos = sec_pos + 1;
      wrap     = next_pos >= sector_bytes || next_pos > POS_MASK;
      if (wrap) next_pos = 0;
      beat_results.delete();
      case (scan_mode)
         SCAN_IDLE: begin
            if (b == 8'h00) begin
               // padding runs to the sector end unless this byte closes it
               scan_mode = wrap ? SCAN_IDLE : SCAN_PADDING;
            end else begin
               clear_record_state();
               rec_len = b;
               rec_pos = 1;
               if (b < MIN_REC_LEN) raise_error(ERR_SHORT);
               else if (eoe) raise_error(ERR_OVERRUN);
               else scan_mode = SCAN_RECORD;
            end
         end
         SCAN_RECORD: begin
            if (eoe && rec_pos + 1 < rec_len) raise_error(ERR_OVERRUN);
            else take_record_byte(b);
         end
         SCAN_PADDING: begin
            if (wrap) scan_mode = SCAN_IDLE;
         end
         default: ;
      endcase
      sec_pos = next_pos & POS_MASK;
      // extent end flags the last result, or makes one of its own
      if (eoe) begin
         if (beat_results.size() == 0) push_result(KIND_END, 8'h00, '0, '0, 1'b0, ERR_NONE);
         r      = beat_results.pop_back();
         r.last = 1'b1;
         beat_results.push_back(r);
         clear_record_state();
         sec_pos   = 0;
         scan_mode = SCAN_IDLE;
      end
      foreach (beat_results[i]) results_due.push_back(beat_results[i]);
      results_parsed += beat_results.size();
   endfunction

   // accepted input beats feed the mirror
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) parse_dir_byte(req_data_byte, req_end_of_extent);
   end

   // ---------------- result check ----------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      dir_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("result beat with nothing due: kind %0d", rsp_kind);
            fail_count++;
         end else begin
            want = results_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("name_char", 32'(want.name_char), 32'(rsp_name_char));
            check_field("extent_lba", want.extent_lba, rsp_extent_lba);
            check_field("data_length", want.data_length, rsp_data_length);
            check_field("is_directory", 32'(want.is_directory), 32'(rsp_is_directory));
            check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // ---------------- receiver and watchdog ----------------

   // random stall, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_granted != holds_asked) begin
         rsp_stall     <= 1'b1;
         hold_left     <= HOLD_CYCLES;
         holds_granted <= holds_granted + 1;
      end else begin
         rsp_stall <= receiver_idle && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("iso9660_dir_record_parser regression: fail");
         $finish;
      end
   end

   // ---------------- sender and register port ----------------

   task automatic send_beat(input logic [7:0] b, input logic eoe);
      int gap;
      if (sender_idle && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_extent <= eoe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_extent();
      if (extent_q.size() == 0) extent_q.push_back(8'h00);
      foreach (extent_q[i]) send_beat(extent_q[i], i == extent_q.size() - 1);
      extent_q.delete();
   endtask

   // wait until every due result is out and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sector_size(input logic [SECTOR_SIZE_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sector_bytes = v;
   endtask

   // ---------------- extent builders ----------------

   function automatic void set_name(input string s);
      name_q.delete();
      for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_name_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) return 8'h41 + 8'($urandom_range(25));
      if (pick < 65) return 8'h61 + 8'($urandom_range(25));
      if (pick < 80) return 8'h30 + 8'($urandom_range(9));
      if (pick < 88) return ($urandom_range(1) != 0) ? 8'h5F : 8'h2E;
      return 8'($urandom);
   endfunction

   function automatic void fill_name(input int n);
      name_q.delete();
      repeat (n) name_q.push_back(rand_name_char());
   endfunction

   function automatic void random_name();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         name_q.delete();
      end else if (pick < 16) begin
         name_q = '{8'($urandom_range(1))};
      end else if (pick < 24) begin
         fill_name($urandom_range(0, 4));
         name_q.push_front(NAME_CUT_CHAR);
      end else begin
         fill_name($urandom_range(1, 12));
         // usual version suffix
         if ($urandom_range(99) < 30) begin
            name_q.push_back(NAME_CUT_CHAR);
            name_q.push_back(8'h31);
         end
      end
   endfunction

   function automatic logic [31:0] rand_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 32'h0000_0000;
      if (pick < 20) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // lays out one record; the flips corrupt the big-endian copies
   function automatic void add_record(input int len, input logic [31:0] lba,
                                      input logic [31:0] sz, input logic [7:0] flags,
                                      input int nlen, input logic [31:0] lba_flip,
                                      input logic [31:0] sz_flip);
      logic [31:0] lba_b;
      logic [31:0] sz_b;
      logic [7:0]  v;
      lba_b = lba ^ lba_flip;
      sz_b  = sz ^ sz_flip;
      for (int p = 0; p < len; p++) begin
         if (p == 0) v = 8'(len);
         else if (p >= LBA_LE_AT && p < LBA_LE_AT + 4) v = lba[8 * (p - LBA_LE_AT) +: 8];
         else if (p >= LBA_BE_AT && p < LBA_BE_AT + 4) v = lba_b[8 * (LBA_BE_AT + 3 - p) +: 8];
         else if (p >= SIZE_LE_AT && p < SIZE_LE_AT + 4) v = sz[8 * (p - SIZE_LE_AT) +: 8];
         else if (p >= SIZE_BE_AT && p < SIZE_BE_AT + 4) v = sz_b[8 * (SIZE_BE_AT + 3 - p) +: 8];
         else if (p == FLAGS_AT) v = flags;
         else if (p == NAME_LEN_AT) v = 8'(nlen);
         else if (p >= NAME_AT && p - NAME_AT < name_q.size()) v = name_q[p - NAME_AT];
         else v = 8'($urandom);
         extent_q.push_back(v);
      end
   endfunction

   function automatic int add_good_record(input logic [31:0] lba, input logic [31:0] sz,
                                          input logic [7:0] flags);
      int len;
      len = NAME_AT + name_q.size() + $urandom_range(0, 3);
      if (len < MIN_LEN) len = MIN_LEN;
      if (len > MAX_LEN) len = MAX_LEN;
      add_record(len, lba, sz, flags, name_q.size(), '0, '0);
      return len;
   endfunction

   function automatic void pad_to_sector();
      if (sector_bytes < 2) begin
         extent_q.push_back(8'h00);
      end else begin
         do extent_q.push_back(8'h00);
         while (extent_q.size() % sector_bytes != 0);
      end
   endfunction

   // returns 1 when the extent has to end right here
   function automatic bit add_broken_record();
      int len;
      int nlen;
      int cut;
      len = MIN_LEN + $urandom_range(0, 20);
      case ($urandom_range(4))
         0: add_record(len, rand_word(), rand_word(), 8'($urandom), 0,
                       32'h1 << $urandom_range(31), '0);
         1: add_record(len, rand_word(), rand_word(), 8'($urandom), 0,
                       '0, 32'h1 << $urandom_range(31));
         2: begin
            nlen = len - NAME_AT + 1 + $urandom_range(0, 30);
            add_record(len, rand_word(), rand_word(), 8'($urandom), nlen, '0, '0);
         end
         3: add_record($urandom_range(1, MIN_LEN - 1), rand_word(), rand_word(), 8'h00, 0,
                       '0, '0);
         default: begin
            // record cut short by the extent end
            len = add_good_record(rand_word(), rand_word(), 8'($urandom));
            cut = $urandom_range(1, (len - 1 < 40) ? len - 1 : 40);
            repeat (cut) void'(extent_q.pop_back());
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void build_random_extent();
      int pick;
      int n_rec;
      n_rec = $urandom_range(1, 4);
      for (int i = 0; i < n_rec; i++) begin
         pick = $urandom_range(99);
         random_name();
         if (pick < 65) begin
            void'(add_good_record(rand_word(), rand_word(), 8'($urandom)));
         end else if (pick < 75) begin
            if (sector_bytes >= MIN_LEN && sector_bytes <= 256) begin
               pad_to_sector();
            end else begin
               // small or large sectors: padding runs to the extent end
               repeat ($urandom_range(1, 3)) extent_q.push_back(8'h00);
               break;
            end
         end else if (pick < 92) begin
            if (add_broken_record()) break;
         end else begin
            repeat ($urandom_range(1, 6)) extent_q.push_back(8'($urandom));
         end
      end
   endfunction

   // ---------------- tests ----------------

   task automatic test_basic_records();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      set_name("readme.txt;1");
      void'(add_good_record(32'h0000_0012, 32'd1000, 8'h00));
      name_q = '{8'h00};
      void'(add_good_record(32'h0000_0014, 32'd2048, DIR_FLAG_MASK));
      name_q = '{8'h01};
      void'(add_good_record(32'h0000_0014, 32'd2048, DIR_FLAG_MASK));
      set_name("");
      void'(add_good_record(32'h0000_0000, 32'h0000_0000, 8'hFD));
      set_name(";1");
      void'(add_good_record(32'h0000_0020, 32'd5, 8'h02));
      // held 0x01 goes out once a second byte follows
      name_q = '{8'h01, 8'h41};
      void'(add_good_record(32'h0000_0021, 32'd6, 8'h00));
      // letter range edges and a 0xff byte
      name_q = '{8'hFF, 8'h7A, 8'h61, 8'h60, 8'h7B, 8'h40, 8'h5B};
      void'(add_good_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      // longest record, extent ends on its last byte
      fill_name(MAX_LEN - NAME_AT);
      add_record(MAX_LEN, 32'h8000_0001, 32'h0001_0000, 8'h00, name_q.size(), '0, '0);
      send_extent();
      // a dot entry alone leaves only the end marker
      name_q = '{8'h00};
      add_record(MIN_LEN, 32'h0000_0030, 32'd2048, DIR_FLAG_MASK, 1, '0, '0);
      send_extent();
      drain_results();
   endtask

   task automatic test_record_errors();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      // short record, then halted bytes until the end
      extent_q.push_back(8'(MIN_LEN - 1));
      repeat (5) extent_q.push_back(8'($urandom));
      send_extent();
      // short length beats extent end on the first byte
      extent_q.push_back(8'd10);
      send_extent();
      extent_q.push_back(8'(MIN_LEN));
      send_extent();
      // overrun after some name bytes are already out
      set_name("abcdef");
      add_record(NAME_AT + 9, 32'd5, 32'd5, 8'h00, 6, '0, '0);
      repeat (3) void'(extent_q.pop_back());
      send_extent();
      set_name("lba");
      add_record(40, 32'd7, 32'd9, 8'h00, 3, 32'h0000_0100, '0);
      void'(add_good_record(32'd1, 32'd1, 8'h00));
      send_extent();
      set_name("size");
      add_record(40, 32'd7, 32'd9, 8'h00, 4, '0, 32'h8000_0000);
      send_extent();
      set_name("toolong");
      add_record(40, 32'd1, 32'd1, 8'h00, 8, '0, '0);
      send_extent();
      set_name("");
      add_record(MIN_LEN, 32'd1, 32'd1, 8'h00, 255, '0, '0);
      send_extent();
      // extent of one padding byte
      extent_q.push_back(8'h00);
      send_extent();
      drain_results();
   endtask

   task automatic test_sector_padding();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      write_sector_size(16'd64);
      set_name("one");
      void'(add_good_record(32'd100, 32'd10, 8'h00));
      pad_to_sector();
      set_name("two");
      void'(add_good_record(32'd101, 32'd11, 8'h02));
      pad_to_sector();
      pad_to_sector();
      set_name("three;2");
      void'(add_good_record(32'd102, 32'd12, 8'h00));
      repeat (3) extent_q.push_back(8'h00);
      send_extent();
      drain_results();
      // one and zero byte sectors: every zero is consumed on its own
      for (int s = 1; s >= 0; s--) begin
         write_sector_size(SECTOR_SIZE_W'(s));
         repeat (2) extent_q.push_back(8'h00);
         set_name("a");
         void'(add_good_record(32'd7, 32'd8, 8'h00));
         extent_q.push_back(8'h00);
         set_name("b");
         void'(add_good_record(32'd9, 32'd10, 8'h02));
         send_extent();
         drain_results();
      end
      write_sector_size(16'hFFFF);
      set_name("x");
      void'(add_good_record(32'd1, 32'd2, 8'h00));
      set_name("y");
      void'(add_good_record(32'd3, 32'd4, 8'h00));
      repeat (4) extent_q.push_back(8'h00);
      send_extent();
      drain_results();
      write_sector_size(SECTOR_SIZE_RESET);
   endtask

   task automatic test_output_backpressure();
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      holds_asked++;
      fill_name(200);
      void'(add_good_record(32'h1234_5678, 32'h0000_0400, 8'h00));
      set_name("tail");
      void'(add_good_record(32'd2, 32'd3, 8'h02));
      send_extent();
      drain_results();
   endtask

   task automatic run_random_phase(input int min_bytes, input int min_results);
      int bytes_sent;
      int results_start;
      bytes_sent    = 0;
      results_start = results_parsed;
      while (bytes_sent < min_bytes || results_parsed - results_start < min_results) begin
         build_random_extent();
         bytes_sent += extent_q.size();
         send_extent();
      end
      drain_results();
   endtask

   task automatic test_random_extents();
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      write_sector_size(SECTOR_SIZE_W'($urandom_range(MIN_LEN, 256)));
      run_random_phase(70, 30);
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      write_sector_size(SECTOR_SIZE_RESET);
      run_random_phase(60, 30);
   endtask

   initial begin
      reset_parser_mirror();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_basic_records();
      test_record_errors();
      test_sector_padding();
      test_output_backpressure();
      test_random_extents();
      drain_results();
      if (fail_count == 0 && results_due.size() == 0) begin
         $display("iso9660_dir_record_parser regression: pass");
      end else begin
         $display("iso9660_dir_record_parser regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/dirp_pkg.sv
hdl/dirp_fifo.sv
hdl/dirp_front.sv
hdl/dirp_back.sv
hdl/iso9660_dir_record_parser.sv
sim/iso9660_dir_record_parser_tb.sv
